/* sv/gtld_pkg.sv */
`default_nettype none

package gtld_pkg;

    // Fixed field widths and limits
    localparam int MAX_CHANNELS = 8;
    localparam int COUNT_BITS   = 23;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 23;
    localparam int ACC_W        = 120;
    localparam int PW           = 116;
    localparam int CNT_W        = 6;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_COEF     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TAIL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_LIMIT = 3'd4;

    // Last MAC step and step counts of the end-of-capture phases
    localparam int MAC_LAST   = 20;
    localparam int DIV_STEPS  = 56;
    localparam int SQRT_STEPS = 28;
    localparam int RAT_STEPS  = 16;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       latch_frame;
        logic       latch_end;
        logic       recip_mul;
        logic       fix;
        logic       res_update;
        logic       mac_en;
        logic [4:0] mac_step;
        logic       div_start;
        logic       div_step;
        logic       sqrt_start;
        logic       sqrt_step;
        logic       rat_start;
        logic       rat_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    // floor(2^20 / d) for channel counts 1..8
    function automatic logic [20:0] recip(input logic [3:0] d);
        logic [20:0] r;
        unique case (d)
            4'd2:    r = 21'd524288;
            4'd3:    r = 21'd349525;
            4'd4:    r = 21'd262144;
            4'd5:    r = 21'd209715;
            4'd6:    r = 21'd174762;
            4'd7:    r = 21'd149796;
            4'd8:    r = 21'd131072;
            default: r = 21'd1048576;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/gtld_datapath.sv */
`default_nettype none

module gtld_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [gtld_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gtld_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic signed [15:0]                  s_chan_a,
    input  wire logic signed [15:0]                  s_chan_b,
    input  wire logic signed [15:0]                  s_chan_c,
    input  wire logic signed [15:0]                  s_chan_d,
    input  wire logic signed [15:0]                  s_chan_e,
    input  wire logic signed [15:0]                  s_chan_f,
    input  wire logic signed [15:0]                  s_chan_g,
    input  wire logic signed [15:0]                  s_chan_h,
    input  wire logic                                s_packet_first,
    input  wire logic                                s_discontinuity,
    input  wire gtld_pkg::cmd_t                      cmd,
    output gtld_pkg::status_t                        status,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [gtld_pkg::COUNT_BITS-1:0]          m_frame_count,
    output logic [15:0]                              m_rms_level,
    output logic [15:0]                              m_tone_ratio_q,
    output logic [15:0]                              m_gap_count,
    output logic                                     m_too_short
);

    localparam int PW    = gtld_pkg::PW;
    localparam int ACC_W = gtld_pkg::ACC_W;
    localparam int CB    = gtld_pkg::COUNT_BITS;

    // Configuration registers
    logic [3:0]          chan_cnt_reg;
    logic signed [17:0]  coef_reg;
    logic [CB-1:0]       skip_reg;
    logic [CB-1:0]       min_tail_reg;
    logic [CB-1:0]       limit_reg;

    // Running capture state
    logic [CB-1:0]       sample_count_reg;
    logic                pkt_nz_reg;
    logic [15:0]         gap_reg;
    logic [55:0]         energy_reg;
    logic signed [47:0]  s1_reg;
    logic signed [47:0]  s2_reg;

    // Per-frame working registers
    logic signed [18:0]  sum_reg;
    logic [18:0]         q0_reg;
    logic signed [16:0]  x_reg;
    logic signed [34:0]  plo_reg;
    logic signed [49:0]  phi_reg;

    // End-of-capture working registers
    logic [CB-1:0]       n_reg;
    logic                shrt_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [95:0]         t_reg;
    logic [PW-1:0]       p_reg;
    logic [PW-1:0]       cross_reg;
    logic                pz_reg;
    logic [78:0]         d_reg;
    logic [23:0]         rem_reg;
    logic [55:0]         quo_reg;
    logic [55:0]         v_reg;
    logic [55:0]         r_reg;
    logic [55:0]         bit_reg;
    logic [PW-1:0]       dsh_reg;
    logic                sat_reg;
    logic [15:0]         q_reg;

    logic                m_valid_reg;
    logic [CB-1:0]       out_count_reg;
    logic [15:0]         out_rms_reg;
    logic [15:0]         out_ratio_reg;
    logic [15:0]         out_gap_reg;
    logic                out_short_reg;

    // Clamp channel count to 1..MAX_CHANNELS
    logic [3:0] cnt_eff;
    always_comb begin
        if (chan_cnt_reg == 4'd0) begin
            cnt_eff = 4'd1;
        end else if (chan_cnt_reg > 4'(gtld_pkg::MAX_CHANNELS)) begin
            cnt_eff = 4'(gtld_pkg::MAX_CHANNELS);
        end else begin
            cnt_eff = chan_cnt_reg;
        end
    end

    // Sum the enabled channels
    logic signed [15:0] chan [8];
    logic signed [18:0] sum_next;
    assign chan[0] = s_chan_a;
    assign chan[1] = s_chan_b;
    assign chan[2] = s_chan_c;
    assign chan[3] = s_chan_d;
    assign chan[4] = s_chan_e;
    assign chan[5] = s_chan_f;
    assign chan[6] = s_chan_g;
    assign chan[7] = s_chan_h;
    always_comb begin
        sum_next = '0;
        for (int c = 0; c < 8; c++) begin
            if (4'(c) < cnt_eff) begin
                sum_next = sum_next + 19'(chan[c]);
            end
        end
    end

    // Divide the channel sum by the count: reciprocal multiply, then one correction
    logic [18:0] sum_mag;
    logic [39:0] qprod;
    logic [22:0] qd;
    logic [22:0] qrem;
    logic [18:0] q_fix;
    assign sum_mag = sum_reg[18] ? 19'(-sum_reg) : 19'(sum_reg);
    assign qprod   = 40'(sum_mag) * 40'(gtld_pkg::recip(cnt_eff));
    assign qd      = 23'(q0_reg) * 23'(cnt_eff);
    assign qrem    = 23'(sum_mag) - qd;
    assign q_fix   = (qrem >= 23'(cnt_eff)) ? q0_reg + 19'd1 : q0_reg;

    // Resonator recurrence pieces
    logic signed [31:0] s1_hi;
    logic signed [16:0] s1_lo;
    logic signed [35:0] plo_rnd;
    logic signed [19:0] rnd;
    logic signed [51:0] s0_w;
    logic signed [33:0] x_sq;
    logic               active;
    logic               analyze;
    assign s1_hi   = s1_reg[47:16];
    assign s1_lo   = {1'b0, s1_reg[15:0]};
    assign plo_rnd = 36'(plo_reg) + 36'sd32768;
    assign rnd     = plo_rnd[35:16];
    assign s0_w    = 52'(x_reg) + 52'(phi_reg) + 52'(rnd) - 52'(s2_reg);
    assign x_sq    = x_reg * x_reg;
    assign active  = (sample_count_reg < limit_reg) && (sample_count_reg != gtld_pkg::COUNT_MAX);
    assign analyze = active && (sample_count_reg >= skip_reg);

    // Magnitudes and sign of the cross term
    logic [47:0] m1;
    logic [47:0] m2;
    logic [23:0] c_mag;
    logic        neg;
    assign m1    = s1_reg[47] ? 48'(-s1_reg) : 48'(s1_reg);
    assign m2    = s2_reg[47] ? 48'(-s2_reg) : 48'(s2_reg);
    assign c_mag = coef_reg[17] ? -24'(coef_reg) : 24'(coef_reg);
    assign neg   = s1_reg[47] ^ s2_reg[47] ^ coef_reg[17];

    // Multiply-accumulate step table
    logic [23:0]       mac_a;
    logic [23:0]       mac_b;
    logic [6:0]        mac_sh;
    logic              mac_clr;
    logic [47:0]       mac_prod;
    logic [ACC_W-1:0]  acc_next;
    always_comb begin
        mac_a   = '0;
        mac_b   = '0;
        mac_sh  = 7'd0;
        mac_clr = 1'b0;
        unique case (cmd.mac_step)
            5'd0:  begin mac_a = m1[23:0];  mac_b = m1[23:0];  mac_clr = 1'b1; end
            5'd1,
            5'd2:  begin mac_a = m1[47:24]; mac_b = m1[23:0];  mac_sh = 7'd24; end
            5'd3:  begin mac_a = m1[47:24]; mac_b = m1[47:24]; mac_sh = 7'd48; end
            5'd4:  begin mac_a = m2[23:0];  mac_b = m2[23:0];  end
            5'd5,
            5'd6:  begin mac_a = m2[47:24]; mac_b = m2[23:0];  mac_sh = 7'd24; end
            5'd7:  begin mac_a = m2[47:24]; mac_b = m2[47:24]; mac_sh = 7'd48; end
            5'd8:  begin mac_a = m1[23:0];  mac_b = m2[23:0];  mac_clr = 1'b1; end
            5'd9:  begin mac_a = m1[47:24]; mac_b = m2[23:0];  mac_sh = 7'd24; end
            5'd10: begin mac_a = m1[23:0];  mac_b = m2[47:24]; mac_sh = 7'd24; end
            5'd11: begin mac_a = m1[47:24]; mac_b = m2[47:24]; mac_sh = 7'd48; end
            5'd12: begin mac_clr = 1'b1; end
            5'd13: begin mac_a = t_reg[23:0];  mac_b = c_mag; end
            5'd14: begin mac_a = t_reg[47:24]; mac_b = c_mag; mac_sh = 7'd24; end
            5'd15: begin mac_a = t_reg[71:48]; mac_b = c_mag; mac_sh = 7'd48; end
            5'd16: begin mac_a = t_reg[95:72]; mac_b = c_mag; mac_sh = 7'd72; end
            5'd17: begin
                mac_a = energy_reg[23:0]; mac_b = {1'b0, n_reg}; mac_clr = 1'b1;
            end
            5'd18: begin
                mac_a = energy_reg[47:24]; mac_b = {1'b0, n_reg}; mac_sh = 7'd24;
            end
            5'd19: begin
                mac_a = {16'd0, energy_reg[55:48]}; mac_b = {1'b0, n_reg}; mac_sh = 7'd48;
            end
            default: begin end
        endcase
    end
    assign mac_prod = 48'(mac_a) * 48'(mac_b);
    assign acc_next = (mac_clr ? '0 : acc_reg) + (ACC_W'(mac_prod) << mac_sh);

    // Long division and square root steps
    logic [24:0]  div_trial;
    logic [55:0]  sq_trial;
    logic [PW-1:0] dsh19;
    assign div_trial = {rem_reg, quo_reg[55]};
    assign sq_trial  = r_reg + bit_reg;
    assign dsh19     = PW'({d_reg, 19'd0});

    // Result qualification
    logic result_ok;
    assign result_ok = !shrt_reg && (n_reg != '0);

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_cnt_reg <= 4'd2;
            coef_reg     <= 18'sd130855;
            skip_reg     <= 23'd48000;
            min_tail_reg <= 23'd24000;
            limit_reg    <= 23'd192000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                gtld_pkg::CFG_CHANNEL_COUNT: chan_cnt_reg <= cfg_data[3:0];
                gtld_pkg::CFG_TONE_COEF:     coef_reg     <= cfg_data[17:0];
                gtld_pkg::CFG_SKIP:          skip_reg     <= cfg_data;
                gtld_pkg::CFG_MIN_TAIL:      min_tail_reg <= cfg_data;
                gtld_pkg::CFG_CAPTURE_LIMIT: limit_reg    <= cfg_data;
                default: begin end
            endcase
        end
    end

    // Update capture state: packet flags, resonator, energy; clear on result load
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.out_load) begin
            sample_count_reg <= '0;
            pkt_nz_reg       <= 1'b0;
            gap_reg          <= '0;
            energy_reg       <= '0;
            s1_reg           <= '0;
            s2_reg           <= '0;
        end else begin
            if (cmd.latch_frame && s_packet_first) begin
                if (pkt_nz_reg && s_discontinuity && gap_reg != 16'hFFFF) begin
                    gap_reg <= gap_reg + 16'd1;
                end
                pkt_nz_reg <= 1'b1;
            end
            if (cmd.res_update && active) begin
                sample_count_reg <= sample_count_reg + 1'b1;
                if (analyze) begin
                    energy_reg <= energy_reg + {22'd0, x_sq};
                    s2_reg     <= s1_reg;
                    s1_reg     <= s0_w[47:0];
                end
            end
        end
    end

    // Advance the per-frame arithmetic
    always_ff @(posedge aclk) begin
        if (cmd.latch_frame) begin
            sum_reg <= sum_next;
        end
        if (cmd.recip_mul) begin
            q0_reg  <= qprod[38:20];
            plo_reg <= 35'(coef_reg) * 35'(s1_lo);
        end
        if (cmd.fix) begin
            x_reg   <= sum_reg[18] ? 17'd0 - 17'(q_fix) : 17'(q_fix);
            phi_reg <= 50'(coef_reg) * 50'(s1_hi);
        end
    end

    // Advance the end-of-capture sequence
    always_ff @(posedge aclk) begin
        if (cmd.latch_end) begin
            n_reg    <= (sample_count_reg > skip_reg) ? sample_count_reg - skip_reg : '0;
            shrt_reg <= ((sample_count_reg > skip_reg) ? sample_count_reg - skip_reg : '0)
                        < min_tail_reg;
        end
        if (cmd.mac_en) begin
            acc_reg <= acc_next;
            unique case (cmd.mac_step)
                5'd8:  p_reg     <= {acc_reg[99:0], 16'd0};
                5'd12: t_reg     <= acc_reg[95:0];
                5'd17: cross_reg <= acc_reg[PW-1:0];
                5'd20: begin
                    d_reg  <= acc_reg[78:0];
                    pz_reg <= !neg && (cross_reg >= p_reg);
                    p_reg  <= neg ? p_reg + cross_reg : p_reg - cross_reg;
                end
                default: begin end
            endcase
        end
        if (cmd.div_start) begin
            rem_reg <= '0;
            quo_reg <= energy_reg;
        end else if (cmd.div_step) begin
            if (div_trial >= {2'b00, n_reg}) begin
                rem_reg <= 24'(div_trial - {2'b00, n_reg});
                quo_reg <= {quo_reg[54:0], 1'b1};
            end else begin
                rem_reg <= div_trial[23:0];
                quo_reg <= {quo_reg[54:0], 1'b0};
            end
        end
        if (cmd.sqrt_start) begin
            v_reg   <= quo_reg;
            r_reg   <= '0;
            bit_reg <= 56'd1 << 54;
        end else if (cmd.sqrt_step) begin
            if (v_reg >= sq_trial) begin
                v_reg <= v_reg - sq_trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.rat_start) begin
            sat_reg <= p_reg >= dsh19;
            dsh_reg <= PW'({d_reg, 18'd0});
            q_reg   <= '0;
        end else if (cmd.rat_step) begin
            if (p_reg >= dsh_reg) begin
                p_reg <= p_reg - dsh_reg;
                q_reg <= {q_reg[14:0], 1'b1};
            end else begin
                q_reg <= {q_reg[14:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_count_reg <= sample_count_reg;
            out_rms_reg   <= result_ok ? r_reg[15:0] : '0;
            out_ratio_reg <= (result_ok && !pz_reg && energy_reg != '0)
                             ? (sat_reg ? 16'hFFFF : q_reg) : '0;
            out_gap_reg   <= gap_reg;
            out_short_reg <= shrt_reg;
        end
    end

    assign status.out_busy = m_valid_reg && !m_ready;
    assign m_valid         = m_valid_reg;
    assign m_frame_count   = out_count_reg;
    assign m_rms_level     = out_rms_reg;
    assign m_tone_ratio_q  = out_ratio_reg;
    assign m_gap_count     = out_gap_reg;
    assign m_too_short     = out_short_reg;

endmodule

`default_nettype wire

/* sv/gtld_ctrl.sv */
`default_nettype none

module gtld_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_capture_end,
    input  wire gtld_pkg::status_t   status,
    output gtld_pkg::cmd_t           cmd
);

    localparam int CW = gtld_pkg::CNT_W;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_DIV  = 9'b000000010,
        ST_FIX  = 9'b000000100,
        ST_RES  = 9'b000001000,
        ST_MAC  = 9'b000010000,
        ST_QDIV = 9'b000100000,
        ST_SQRT = 9'b001000000,
        ST_RAT  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Sequence frame and end-of-capture phases
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cnt_next = '0;
                    if (s_capture_end) begin
                        cmd.latch_end = 1'b1;
                        state_next    = ST_MAC;
                    end else begin
                        cmd.latch_frame = 1'b1;
                        state_next      = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                cmd.recip_mul = 1'b1;
                state_next    = ST_FIX;
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_RES;
            end
            ST_RES: begin
                cmd.res_update = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_MAC: begin
                cmd.mac_en   = 1'b1;
                cmd.mac_step = cnt_reg[4:0];
                if (cnt_reg == CW'(gtld_pkg::MAC_LAST)) begin
                    cnt_next   = '0;
                    state_next = ST_QDIV;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_QDIV: begin
                cmd.div_start = (cnt_reg == '0);
                cmd.div_step  = (cnt_reg != '0);
                if (cnt_reg == CW'(gtld_pkg::DIV_STEPS)) begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_start = (cnt_reg == '0);
                cmd.sqrt_step  = (cnt_reg != '0);
                if (cnt_reg == CW'(gtld_pkg::SQRT_STEPS)) begin
                    cnt_next   = '0;
                    state_next = ST_RAT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RAT: begin
                cmd.rat_start = (cnt_reg == '0);
                cmd.rat_step  = (cnt_reg != '0);
                if (cnt_reg == CW'(gtld_pkg::RAT_STEPS)) begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_QDIV) |-> (cnt_reg <= CW'(gtld_pkg::DIV_STEPS)))
        else $error("divider step count overran");

    a_out_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !status.out_busy) |=> (state_reg == ST_IDLE))
        else $error("result load did not return to idle");

    a_frame_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_valid && !s_capture_end) |=> (state_reg == ST_DIV))
        else $error("frame request did not enter the sample path");

endmodule

`default_nettype wire

/* sv/goertzel_tone_level_detector_unit.sv */
// Goertzel tone level detector.
// Input channel (s_valid/s_ready): one audio frame per request, eight Q1.15
// channels plus packet_first, discontinuity and capture_end flags. The first
// channel_count channels are averaged to mono, counted, and after skip_samples
// fed to the resonator and the energy sum.
// A frame request passes through the sum, reciprocal multiply, correction
// and resonator update steps in order; no new frame is taken until it ends.
// A capture_end request runs, before its result shows, a 21-step shared
// 24x24 multiply-accumulate sequence, a 56-step energy/n divider, a
// 28-step square root and a ratio divider. No frame is taken until the
// result is loaded.
// Result channel (m_valid/m_ready): count, RMS, tone ratio, gap count and
// too-short flag, held in an output register. Frames keep flowing while a
// result waits; a second capture_end waits before loading until the first
// result is taken.
// Reset (aresetn low, synchronous) restores the default configuration and
// clears all capture state. Configuration is a plain write port, to be
// written only while no request is in flight.
`default_nettype none

module goertzel_tone_level_detector_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [gtld_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gtld_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [15:0]               s_chan_a,
    input  wire logic signed [15:0]               s_chan_b,
    input  wire logic signed [15:0]               s_chan_c,
    input  wire logic signed [15:0]               s_chan_d,
    input  wire logic signed [15:0]               s_chan_e,
    input  wire logic signed [15:0]               s_chan_f,
    input  wire logic signed [15:0]               s_chan_g,
    input  wire logic signed [15:0]               s_chan_h,
    input  wire logic                             s_packet_first,
    input  wire logic                             s_discontinuity,
    input  wire logic                             s_capture_end,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [gtld_pkg::COUNT_BITS-1:0]       m_frame_count,
    output logic [15:0]                           m_rms_level,
    output logic [15:0]                           m_tone_ratio_q,
    output logic [15:0]                           m_gap_count,
    output logic                                  m_too_short
);

    gtld_pkg::cmd_t    cmd;
    gtld_pkg::status_t status;

    gtld_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_capture_end (s_capture_end),
        .status        (status),
        .cmd           (cmd)
    );

    gtld_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_chan_a        (s_chan_a),
        .s_chan_b        (s_chan_b),
        .s_chan_c        (s_chan_c),
        .s_chan_d        (s_chan_d),
        .s_chan_e        (s_chan_e),
        .s_chan_f        (s_chan_f),
        .s_chan_g        (s_chan_g),
        .s_chan_h        (s_chan_h),
        .s_packet_first  (s_packet_first),
        .s_discontinuity (s_discontinuity),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_count   (m_frame_count),
        .m_rms_level     (m_rms_level),
        .m_tone_ratio_q  (m_tone_ratio_q),
        .m_gap_count     (m_gap_count),
        .m_too_short     (m_too_short)
    );

endmodule

`default_nettype wire

/* sim/testbench.sv */
`default_nettype none

module testbench;

    localparam int IDLE_LIMIT   = 6000;
    localparam int SETTLE_WAIT  = 250;
    localparam int LONG_HOLD    = 700;
    localparam int ITEM_TARGET  = 1550;

    typedef struct packed {
        logic [7:0][15:0] ch;
        logic             pf;
        logic             disc;
        logic             fin;
    } frame_t;

    typedef struct packed {
        logic [22:0] cnt;
        logic [15:0] rms;
        logic [15:0] ratio;
        logic [15:0] gaps;
        logic        short_flag;
    } report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [gtld_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gtld_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_chan_a = '0, s_chan_b = '0, s_chan_c = '0, s_chan_d = '0;
    logic signed [15:0] s_chan_e = '0, s_chan_f = '0, s_chan_g = '0, s_chan_h = '0;
    logic s_packet_first = 1'b0, s_discontinuity = 1'b0, s_capture_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [gtld_pkg::COUNT_BITS-1:0] m_frame_count;
    logic [15:0] m_rms_level, m_tone_ratio_q, m_gap_count;
    logic m_too_short;

    goertzel_tone_level_detector_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_chan_a(s_chan_a), .s_chan_b(s_chan_b), .s_chan_c(s_chan_c), .s_chan_d(s_chan_d),
        .s_chan_e(s_chan_e), .s_chan_f(s_chan_f), .s_chan_g(s_chan_g), .s_chan_h(s_chan_h),
        .s_packet_first(s_packet_first), .s_discontinuity(s_discontinuity),
        .s_capture_end(s_capture_end),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_frame_count(m_frame_count), .m_rms_level(m_rms_level),
        .m_tone_ratio_q(m_tone_ratio_q), .m_gap_count(m_gap_count),
        .m_too_short(m_too_short)
    );

    always #5 aclk = ~aclk;

    // Shadow configuration
    logic [3:0]         cfg_chans;
    logic signed [17:0] cfg_coef;
    logic [22:0]        cfg_skip, cfg_min_tail, cfg_cap;

    // Shadow capture state
    logic [22:0]        smp_cnt;
    logic               pkt_seen;
    logic [15:0]        gap_tot;
    logic [55:0]        energy;
    logic signed [47:0] res_s1, res_s2;

    frame_t  pending_frames[$];
    report_t expected_reports[$];
    frame_t  cur_frame;

    int  mismatches = 0;
    int  frames_sent = 0;
    int  ends_sent = 0;
    int  reports_checked = 0;
    bit  in_taken = 0, out_taken = 0, offering = 0;
    bit  tx_calm = 0, rx_calm = 0, rx_hold_req = 0;
    int  tx_gap = 0, rx_gap = 0, hold_left = 0, idle_cycles = 0;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] probe;
        r = '0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= r + probe) begin
                v = v - (r + probe);
                r = (r >> 1) + probe;
            end else begin
                r = r >> 1;
            end
            probe = probe >> 2;
        end
        return r;
    endfunction

    task automatic clear_capture();
        smp_cnt = '0;
        pkt_seen = 1'b0;
        gap_tot = '0;
        energy = '0;
        res_s1 = '0;
        res_s2 = '0;
    endtask

    // Advance the shadow detector by one accepted request
    task automatic tone_detector_step(input frame_t f);
        int nch;
        int sum;
        int x;
        int i;
        logic [22:0] n;
        logic signed [79:0] acc;
        logic signed [127:0] a, b, c, pw;
        logic [127:0] d;
        report_t r;
        if (f.fin) begin
            n = (smp_cnt > cfg_skip) ? smp_cnt - cfg_skip : '0;
            r = '0;
            r.cnt = smp_cnt;
            r.gaps = gap_tot;
            r.short_flag = (n < cfg_min_tail);
            if (!r.short_flag && n != 0) begin
                r.rms = 16'(int_sqrt(64'(energy / n)));
                a = 128'(res_s1);
                b = 128'(res_s2);
                c = 128'(cfg_coef);
                pw = ((a * a + b * b) <<< 16) - c * a * b;
                d = 128'(n);
                d = d * 128'(energy);
                if (pw > 0 && energy != 0) begin
                    if ($unsigned(pw) >= (d << 19)) r.ratio = 16'hFFFF;
                    else r.ratio = 16'($unsigned(pw) / (d << 3));
                end
            end
            expected_reports.push_back(r);
            clear_capture();
        end else begin
            // Count discontinuous packet openings after the first
            if (f.pf) begin
                if (pkt_seen && f.disc && gap_tot != 16'hFFFF) gap_tot = gap_tot + 16'd1;
                pkt_seen = 1'b1;
            end
            if (smp_cnt < cfg_cap && smp_cnt != gtld_pkg::COUNT_MAX) begin
                if (cfg_chans == 4'd0) nch = 1;
                else if (cfg_chans > 4'(gtld_pkg::MAX_CHANNELS)) nch = gtld_pkg::MAX_CHANNELS;
                else nch = int'(cfg_chans);
                sum = 0;
                for (i = 0; i < nch; i++) sum = sum + int'($signed(f.ch[i]));
                x = sum / nch;
                if (smp_cnt >= cfg_skip) begin
                    acc = 80'(cfg_coef);
                    acc = (acc * 80'(res_s1) + 80'sd32768) >>> 16;
                    acc = acc + 80'(x) - 80'(res_s2);
                    res_s2 = res_s1;
                    res_s1 = acc[47:0];
                    energy = energy + 56'(x * x);
                end
                smp_cnt = smp_cnt + 23'd1;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Observe handshakes, predict and compare
    always @(posedge aclk) begin
        report_t e;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tone_detector_step(cur_frame);
                in_taken = 1;
            end
            if (m_valid && m_ready) begin
                out_taken = 1;
                if (expected_reports.size() == 0) begin
                    $error("result with no request pending");
                    mismatches++;
                end else begin
                    e = expected_reports.pop_front();
                    check_field("frame_count", 32'(e.cnt), 32'(m_frame_count));
                    check_field("rms_level", 32'(e.rms), 32'(m_rms_level));
                    check_field("tone_ratio_q", 32'(e.ratio), 32'(m_tone_ratio_q));
                    check_field("gap_count", 32'(e.gaps), 32'(m_gap_count));
                    check_field("too_short", 32'(e.short_flag), 32'(m_too_short));
                    reports_checked++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("watchdog: no progress, %0d results outstanding",
                     expected_reports.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Request driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                in_taken = 0;
                offering = 0;
                tx_gap = tx_calm ? 0 : $urandom_range(0, 13);
            end
            if (!offering) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_frames.size() > 0) begin
                    cur_frame = pending_frames.pop_front();
                    offering = 1;
                    s_chan_a <= cur_frame.ch[0];
                    s_chan_b <= cur_frame.ch[1];
                    s_chan_c <= cur_frame.ch[2];
                    s_chan_d <= cur_frame.ch[3];
                    s_chan_e <= cur_frame.ch[4];
                    s_chan_f <= cur_frame.ch[5];
                    s_chan_g <= cur_frame.ch[6];
                    s_chan_h <= cur_frame.ch[7];
                    s_packet_first <= cur_frame.pf;
                    s_discontinuity <= cur_frame.disc;
                    s_capture_end <= cur_frame.fin;
                end
            end
            s_valid <= offering;
        end
    end

    // Result receiver, with an optional long hold-off
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_taken) begin
                out_taken = 0;
                rx_gap = rx_calm ? 0 : $urandom_range(0, 13);
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (rx_hold_req) begin
                hold_left = LONG_HOLD;
                rx_hold_req = 0;
            end else if (rx_gap > 0) begin
                rx_gap--;
            end
            m_ready <= (hold_left == 0 && rx_gap == 0);
        end
    end

    task automatic reg_write(input logic [gtld_pkg::CFG_IDX_W-1:0] idx,
                             input logic [22:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        unique case (idx)
            gtld_pkg::CFG_CHANNEL_COUNT: cfg_chans = val[3:0];
            gtld_pkg::CFG_TONE_COEF:     cfg_coef = val[17:0];
            gtld_pkg::CFG_SKIP:          cfg_skip = val;
            gtld_pkg::CFG_MIN_TAIL:      cfg_min_tail = val;
            gtld_pkg::CFG_CAPTURE_LIMIT: cfg_cap = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [3:0] ch, input logic [17:0] coef,
                            input logic [22:0] skip, input logic [22:0] tail,
                            input logic [22:0] cap);
        reg_write(gtld_pkg::CFG_CHANNEL_COUNT, 23'(ch));
        reg_write(gtld_pkg::CFG_TONE_COEF, 23'(coef));
        reg_write(gtld_pkg::CFG_SKIP, skip);
        reg_write(gtld_pkg::CFG_MIN_TAIL, tail);
        reg_write(gtld_pkg::CFG_CAPTURE_LIMIT, cap);
    endtask

    // Wait until every request is taken and every result has come back
    task automatic drain();
        while (pending_frames.size() != 0 || offering || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    function automatic frame_t pattern_frame(input logic [15:0] even_v,
                                             input logic [15:0] odd_v,
                                             input logic pf, input logic disc,
                                             input logic fin);
        frame_t f;
        for (int i = 0; i < 8; i++) f.ch[i] = i[0] ? odd_v : even_v;
        f.pf = pf;
        f.disc = disc;
        f.fin = fin;
        return f;
    endfunction

    function automatic frame_t random_frame(input logic fin);
        frame_t f;
        int mode;
        logic [15:0] common;
        mode = $urandom_range(0, 3);
        common = 16'($urandom);
        for (int i = 0; i < 8; i++) begin
            case (mode)
                0: f.ch[i] = 16'($urandom);
                1: f.ch[i] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                2: f.ch[i] = 16'($signed(10'($urandom)));
                default: f.ch[i] = common;
            endcase
        end
        f.pf = ($urandom_range(0, 3) == 0);
        f.disc = 1'($urandom_range(0, 1));
        f.fin = fin;
        return f;
    endfunction

    task automatic queue_frame(input frame_t f);
        pending_frames.push_back(f);
        if (f.fin) ends_sent++;
        else frames_sent++;
    endtask

    initial begin
        int phase;
        int segs;
        int len;
        int max_len;
        logic [22:0] cap;
        logic [22:0] skip;
        logic [22:0] tail;
        cfg_chans = 4'd2;
        cfg_coef = 18'sd130855;
        cfg_skip = 23'd48000;
        cfg_min_tail = 23'd24000;
        cfg_cap = 23'd192000;
        clear_capture();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Defaults: everything still inside the skip window
        queue_frame(random_frame(1'b0));
        queue_frame(random_frame(1'b0));
        queue_frame(random_frame(1'b1));
        drain();

        // All channels, largest coefficient, no skip, no tail minimum
        set_regs(4'd8, 18'h1FFFF, 23'd0, 23'd0, 23'h7FFFFF);
        queue_frame(pattern_frame(16'h0, 16'h0, 1'b0, 1'b0, 1'b1));
        queue_frame(pattern_frame(16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 1'b0));
        queue_frame(pattern_frame(16'h8000, 16'h8000, 1'b1, 1'b1, 1'b0));
        queue_frame(pattern_frame(16'h7FFF, 16'h8000, 1'b0, 1'b1, 1'b0));
        queue_frame(pattern_frame(16'hFFFF, 16'h0001, 1'b1, 1'b0, 1'b0));
        queue_frame(pattern_frame(16'h8000, 16'h7FFF, 1'b1, 1'b1, 1'b1));
        drain();

        // Channel count zero acts as one, most negative coefficient, capture limit hit
        set_regs(4'd0, 18'h20000, 23'd1, 23'd2, 23'd3);
        for (int i = 0; i < 5; i++) queue_frame(random_frame(1'b0));
        queue_frame(random_frame(1'b1));
        queue_frame(random_frame(1'b0));
        queue_frame(random_frame(1'b1));
        drain();

        // Channel count above range, skip everything; then capture limit zero
        set_regs(4'd15, 18'd65536, 23'h7FFFFF, 23'd0, 23'd10);
        for (int i = 0; i < 3; i++) queue_frame(random_frame(1'b0));
        queue_frame(random_frame(1'b1));
        drain();
        reg_write(gtld_pkg::CFG_CAPTURE_LIMIT, 23'd0);
        queue_frame(pattern_frame(16'h1234, 16'h4321, 1'b1, 1'b1, 1'b0));
        queue_frame(pattern_frame(16'h1234, 16'h4321, 1'b1, 1'b1, 1'b0));
        queue_frame(random_frame(1'b1));
        drain();

        // Largest tail minimum: always too short
        set_regs(4'd1, 18'd0, 23'd0, 23'h7FFFFF, 23'h7FFFFF);
        for (int i = 0; i < 4; i++) queue_frame(random_frame(1'b0));
        queue_frame(random_frame(1'b1));
        drain();

        // Random phases: capture runs of random length under random settings
        phase = 0;
        while (frames_sent + ends_sent < ITEM_TARGET) begin
            skip = 23'($urandom_range(0, 24));
            tail = 23'($urandom_range(0, 30));
            case ($urandom_range(0, 7))
                0: cap = 23'h7FFFFF;
                1: cap = 23'd0;
                default: cap = 23'($urandom_range(1, 70));
            endcase
            if ($urandom_range(0, 9) == 0) skip = 23'h7FFFFF;
            if ($urandom_range(0, 9) == 0) tail = 23'h7FFFFF;
            set_regs(4'($urandom_range(0, 15)), 18'($urandom), skip, tail, cap);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            max_len = 50;
            // Fill the block behind a stalled receiver
            if (phase == 2) begin
                tx_calm = 1;
                rx_hold_req = 1;
                max_len = 3;
            end
            segs = $urandom_range(3, 6);
            for (int s = 0; s < segs; s++) begin
                len = $urandom_range(0, max_len);
                for (int i = 0; i < len; i++) queue_frame(random_frame(1'b0));
                queue_frame(random_frame(1'b1));
            end
            drain();
            phase++;
        end

        $display("covered %0d frames and %0d capture ends over %0d random phases",
                 frames_sent, ends_sent, phase);
        $display("checked %0d results", reports_checked);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
